/* rtl/ale_pkg.sv */
// ale_pkg: shared constants, codes and structs of the array list engine
`timescale 1ns / 1ps

package ale_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FIDX_W = 4;
  localparam int unsigned LL_W   = 5;
  localparam int unsigned CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_SEARCH  = 3'd2,
    REQ_INSERT  = 3'd3,
    REQ_DISPLAY = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
    logic                    start_new;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic [FIDX_W-1:0]       found_index;
    logic signed [VAL_W-1:0] element;
    logic [LL_W-1:0]         list_length;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/ale_mem.sv */
// ale_mem: element store, one write port and one registered read port
`timescale 1ns / 1ps

module ale_mem (
  input  logic                      clk_i,
  input  ale_pkg::mem_req_t         mem_req_i,
  output logic [ale_pkg::VAL_W-1:0] rd_data_o
);
  import ale_pkg::*;

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rd_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/ale_seq.sv */
// ale_seq: request sequencer driving the element store, with the search comparator
`timescale 1ns / 1ps

module ale_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ale_pkg::req_t             in_req_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output ale_pkg::res_t             res_o,
  output ale_pkg::mem_req_t         mem_req_o,
  input  logic [ale_pkg::VAL_W-1:0] rd_data_i
);
  import ale_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SHIFT_RD = 8'b0000_0010,
    S_SHIFT_WR = 8'b0000_0100,
    S_SRCH_RD  = 8'b0000_1000,
    S_SRCH_CMP = 8'b0001_0000,
    S_DISP_RD  = 8'b0010_0000,
    S_DISP_OUT = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             ins_q, ins_d;
  status_e          st_q, st_d;
  logic [LEN_W-1:0] base_len;
  logic [LEN_W-1:0] idx_inc;
  logic [LEN_W-1:0] idx_dec;
  logic             disp_last;

  assign idx_inc   = idx_q + LEN_W'(1);
  assign idx_dec   = idx_q - LEN_W'(1);
  assign base_len  = in_req_i.start_new ? '0 : len_q;
  assign disp_last = (idx_inc == len_q);

  always_comb begin
    state_d          = state_q;
    len_d            = len_q;
    idx_d            = idx_q;
    pos_d            = pos_q;
    val_d            = val_q;
    ins_d            = ins_q;
    st_d             = st_q;
    mem_req_o        = '0;
    mem_req_o.wdata  = val_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d = in_req_i.item_value;
          idx_d = '0;
          pos_d = LEN_W'(CMP_W'(in_req_i.position));
          case (in_req_i.req_type)
            REQ_APPEND: begin
              state_d = S_RESULT;
              if (CMP_W'(base_len) >= CMP_W'(DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = IDX_W'(base_len);
                mem_req_o.wdata = in_req_i.item_value;
                len_d           = base_len + LEN_W'(1);
                st_d            = ST_OK;
              end
            end
            REQ_DELETE: begin
              if (CMP_W'(in_req_i.position) >= CMP_W'(len_q)) begin
                st_d    = ST_BADPOS;
                state_d = S_RESULT;
              end else begin
                idx_d   = LEN_W'(CMP_W'(in_req_i.position));
                ins_d   = 1'b0;
                state_d = S_SHIFT_RD;
              end
            end
            REQ_INSERT: begin
              if (CMP_W'(in_req_i.position) > CMP_W'(len_q)) begin
                st_d    = ST_BADPOS;
                state_d = S_RESULT;
              end else if (CMP_W'(len_q) >= CMP_W'(DEPTH)) begin
                st_d    = ST_FULL;
                state_d = S_RESULT;
              end else begin
                idx_d   = len_q;
                ins_d   = 1'b1;
                state_d = S_SHIFT_RD;
              end
            end
            REQ_SEARCH: begin
              state_d = S_SRCH_RD;
            end
            REQ_DISPLAY: begin
              if (len_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_RESULT;
              end else begin
                state_d = S_DISP_RD;
              end
            end
            default: begin
              st_d    = ST_OK;
              state_d = S_RESULT;
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (ins_q) begin
          if (idx_q > pos_q) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = IDX_W'(idx_dec);
            state_d         = S_SHIFT_WR;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = IDX_W'(pos_q);
            len_d           = len_q + LEN_W'(1);
            idx_d           = '0;
            st_d            = ST_OK;
            state_d         = S_RESULT;
          end
        end else begin
          if (idx_inc < len_q) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = IDX_W'(idx_inc);
            state_d         = S_SHIFT_WR;
          end else begin
            len_d   = len_q - LEN_W'(1);
            idx_d   = '0;
            st_d    = ST_OK;
            state_d = S_RESULT;
          end
        end
      end
      S_SHIFT_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IDX_W'(idx_q);
        mem_req_o.wdata = rd_data_i;
        idx_d           = ins_q ? idx_dec : idx_inc;
        state_d         = S_SHIFT_RD;
      end
      S_SRCH_RD: begin
        if (idx_q < len_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(idx_q);
          state_d         = S_SRCH_CMP;
        end else begin
          idx_d   = '0;
          st_d    = ST_NOTFOUND;
          state_d = S_RESULT;
        end
      end
      S_SRCH_CMP: begin
        if (rd_data_i == val_q) begin
          st_d    = ST_OK;
          state_d = S_RESULT;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SRCH_RD;
        end
      end
      S_DISP_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = IDX_W'(idx_q);
        state_d         = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        if (res_ready_i) begin
          if (disp_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_DISP_RD;
          end
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESULT) || (state_q == S_DISP_OUT);

  always_comb begin
    res_o.list_length = LL_W'(len_q);
    res_o.found_index = FIDX_W'(idx_q);
    if (state_q == S_DISP_OUT) begin
      res_o.status  = ST_OK;
      res_o.element = rd_data_i;
      res_o.last    = disp_last;
    end else begin
      res_o.status  = st_q;
      res_o.element = '0;
      res_o.last    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      idx_q   <= '0;
      ins_q   <= 1'b0;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      ins_q   <= ins_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
  end

  // length stays within capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(len_q) <= CMP_W'(DEPTH))
    else $error("list length beyond capacity");

  // a taken single result always frees the engine
  a_result_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && res_ready_i) |=> (state_q == S_IDLE))
    else $error("engine not idle after result");

  // length moves by one, or restarts at one on a fresh append
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |->
      (len_q == $past(len_q) + LEN_W'(1) || len_q == $past(len_q) - LEN_W'(1) ||
       len_q == LEN_W'(1)))
    else $error("length jumped");

  // store is only written while shifting or on an accepted word
  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == S_SHIFT_WR || state_q == S_SHIFT_RD ||
                      (state_q == S_IDLE && in_valid_i)))
    else $error("unexpected store write");

endmodule

/* rtl/array_list_engine.sv */
// array_list_engine: top level with stream ports and the result register
`timescale 1ns / 1ps

// Bounded ordered list of up to 16 signed 32-bit elements. Each input word is
// one request (append, delete, search, insert, display) and gives one result
// word, or one word per element for display of a non-empty list, the final one
// with tlast. The list lives in a store with one write port and a registered
// read port, and one comparator serves search. Every stored element that is
// moved passes through S_SHIFT_RD and S_SHIFT_WR, and every one that is checked
// through S_SRCH_RD and S_SRCH_CMP. Output stalls can hold the engine in its
// result states. s_axis_tready is low while a request is in work; a finished
// word waits in the output register while the next request is taken.

module array_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[4:0], item_value[36:5], start_new[37]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // found_index[3:0], element[35:4], list_length[40:36]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast
);
  import ale_pkg::*;

  req_t     in_req;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  mem_req_t mem_req;
  logic [VAL_W-1:0] rd_data;
  logic     out_valid_q;
  res_t     out_q;

  assign in_req.req_type   = s_axis_tuser;
  assign in_req.position   = s_axis_tdata[4:0];
  assign in_req.item_value = s_axis_tdata[36:5];
  assign in_req.start_new  = s_axis_tdata[37];

  assign res_ready = !out_valid_q || m_axis_tready;

  ale_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (in_req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  ale_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.list_length, out_q.element, out_q.found_index};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule
